// File: rtl/core/pida_pkg.sv
`timescale 1ns / 1ps

package pida_pkg;

  // Fixed field widths of the item and result channels
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  // Default number of array entries
  localparam int unsigned DEPTH_DEF = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DEL,
    S_INS,
    S_INS_LAST,
    S_RESULT
  } state_e;

endpackage

// File: rtl/core/pida_if.sv
`timescale 1ns / 1ps

// Command channel
interface pida_in_if;
  logic                                valid;
  logic                                ready;
  logic [pida_pkg::CMD_W-1:0]          command;
  logic [pida_pkg::POS_W-1:0]          position;
  logic signed [pida_pkg::DATA_W-1:0]  value;

  modport source (output valid, output command, output position, output value, input ready);
  modport sink   (input valid, input command, input position, input value, output ready);
endinterface

// Result channel
interface pida_out_if;
  logic                                valid;
  logic                                ready;
  logic [pida_pkg::STAT_W-1:0]         status;
  logic signed [pida_pkg::DATA_W-1:0]  data;
  logic [pida_pkg::COUNT_W-1:0]        count_after;

  modport source (output valid, output status, output data, output count_after, input ready);
  modport sink   (input valid, input status, input data, input count_after, output ready);
endinterface

// File: rtl/core/pida_mem.sv
`timescale 1ns / 1ps

// Entry store: one write port, one read port, registered read data
module pida_mem #(
  parameter int unsigned DEPTH = pida_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [pida_pkg::DATA_W-1:0] wr_data_i,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [pida_pkg::DATA_W-1:0] rd_data_o
);

  logic [pida_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [pida_pkg::DATA_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/pida_ctrl.sv
`timescale 1ns / 1ps

// Command sequencer: checks the request, moves entries one per cycle
// through the store and registers the result
module pida_ctrl #(
  parameter int unsigned DEPTH = pida_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pida_in_if.sink                     in_i,
  pida_out_if.source                  out_o,
  output logic                        wr_en_o,
  output logic [AW-1:0]               wr_addr_o,
  output logic [pida_pkg::DATA_W-1:0] wr_data_o,
  output logic                        rd_en_o,
  output logic [AW-1:0]               rd_addr_o,
  input  logic [pida_pkg::DATA_W-1:0] rd_data_i
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = (CW > pida_pkg::POS_W) ? CW : pida_pkg::POS_W;

  pida_pkg::state_e            state_q, state_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [AW-1:0]               pos_q, r_q, r_d;
  logic [pida_pkg::DATA_W-1:0] val_q, data_q, data_d;
  pida_pkg::status_e           stat_q, stat_d;

  logic                        out_valid_q;
  pida_pkg::status_e           out_stat_q;
  logic [pida_pkg::DATA_W-1:0] out_data_q;
  logic [pida_pkg::COUNT_W-1:0] out_cnt_q;

  pida_pkg::cmd_e              cmd;
  logic [WW-1:0]               pos_w, cnt_w, cnt_w1, r_w1;
  logic [AW-1:0]               pos_a;
  logic                        accept, ins_range, full, dr_range, ins_tail;
  logic                        del_done, out_free;

  // Request decode against the current count
  assign cmd       = pida_pkg::cmd_e'(in_i.command);
  assign pos_w     = WW'(in_i.position);
  assign pos_a     = pos_w[AW-1:0];
  assign cnt_w     = WW'(cnt_q);
  assign cnt_w1    = WW'(cnt_q) - WW'(1);
  assign ins_range = pos_w > cnt_w;
  assign full      = cnt_q == CW'(DEPTH);
  assign dr_range  = pos_w >= cnt_w;
  assign ins_tail  = pos_w == cnt_w;
  assign accept    = in_i.valid && in_i.ready;
  assign r_w1      = WW'(r_q) + WW'(1);
  assign del_done  = r_w1 >= cnt_w;
  assign out_free  = !out_valid_q || out_o.ready;

  assign in_i.ready = (state_q == pida_pkg::S_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pida_pkg::S_IDLE: begin
        if (in_i.valid) begin
          case (cmd)
            pida_pkg::CMD_INSERT: begin
              if (ins_range || full || ins_tail) state_d = pida_pkg::S_RESULT;
              else                               state_d = pida_pkg::S_INS;
            end
            pida_pkg::CMD_DELETE: begin
              state_d = dr_range ? pida_pkg::S_RESULT : pida_pkg::S_DEL;
            end
            pida_pkg::CMD_READ: begin
              state_d = dr_range ? pida_pkg::S_RESULT : pida_pkg::S_READ;
            end
            default: state_d = pida_pkg::S_RESULT;
          endcase
        end
      end
      pida_pkg::S_READ:     state_d = pida_pkg::S_RESULT;
      pida_pkg::S_DEL:      if (del_done) state_d = pida_pkg::S_RESULT;
      pida_pkg::S_INS:      if (r_q == pos_q) state_d = pida_pkg::S_INS_LAST;
      pida_pkg::S_INS_LAST: state_d = pida_pkg::S_RESULT;
      pida_pkg::S_RESULT:   if (out_free) state_d = pida_pkg::S_IDLE;
      default:              state_d = pida_pkg::S_IDLE;
    endcase
  end

  // Store accesses and working registers
  always_comb begin
    wr_en_o   = 1'b0;
    wr_addr_o = r_q + AW'(1);
    wr_data_o = rd_data_i;
    rd_en_o   = 1'b0;
    rd_addr_o = pos_a;
    r_d       = r_q;
    cnt_d     = cnt_q;
    data_d    = data_q;
    stat_d    = stat_q;
    case (state_q)
      pida_pkg::S_IDLE: begin
        if (accept) begin
          data_d = '0;
          stat_d = pida_pkg::ST_OK;
          case (cmd)
            pida_pkg::CMD_INSERT: begin
              if (ins_range) begin
                stat_d = pida_pkg::ST_RANGE;
              end else if (full) begin
                stat_d = pida_pkg::ST_FULL;
              end else if (ins_tail) begin
                // append: no entries to move
                wr_en_o   = 1'b1;
                wr_addr_o = pos_a;
                wr_data_o = in_i.value;
                cnt_d     = cnt_q + CW'(1);
              end else begin
                // start the upward move at the last entry
                rd_en_o   = 1'b1;
                rd_addr_o = cnt_w1[AW-1:0];
                r_d       = cnt_w1[AW-1:0];
              end
            end
            pida_pkg::CMD_DELETE, pida_pkg::CMD_READ: begin
              if (dr_range) begin
                stat_d = pida_pkg::ST_RANGE;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = pos_a;
                r_d       = pos_a;
              end
            end
            default: ;
          endcase
        end
      end
      pida_pkg::S_READ: begin
        data_d = rd_data_i;
      end
      pida_pkg::S_DEL: begin
        // rd_data holds entry r; it moves down to r-1
        if (r_q == pos_q) begin
          data_d = rd_data_i;
        end else begin
          wr_en_o   = 1'b1;
          wr_addr_o = r_q - AW'(1);
        end
        if (del_done) begin
          cnt_d = cnt_q - CW'(1);
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = r_q + AW'(1);
          r_d       = r_q + AW'(1);
        end
      end
      pida_pkg::S_INS: begin
        // rd_data holds entry r; it moves up to r+1
        wr_en_o = 1'b1;
        if (r_q != pos_q) begin
          rd_en_o   = 1'b1;
          rd_addr_o = r_q - AW'(1);
          r_d       = r_q - AW'(1);
        end
      end
      pida_pkg::S_INS_LAST: begin
        wr_en_o   = 1'b1;
        wr_addr_o = pos_q;
        wr_data_o = val_q;
        cnt_d     = cnt_q + CW'(1);
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pida_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == pida_pkg::S_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    data_q <= data_d;
    stat_q <= stat_d;
    if (accept) begin
      pos_q <= pos_a;
      val_q <= in_i.value;
    end
    if (state_q == pida_pkg::S_RESULT && out_free) begin
      out_stat_q <= stat_q;
      out_data_q <= data_q;
      out_cnt_q  <= cnt_w[pida_pkg::COUNT_W-1:0];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_stat_q;
  assign out_o.data        = out_data_q;
  assign out_o.count_after = out_cnt_q;

endmodule

// File: rtl/core/positional_insert_delete_array_top.sv
// From transfer in to result valid: a refused command, a no-op or an append goes
// straight to the result state; a read passes through the read state; a delete moves
// every entry behind the position down by one; an insert inside the list moves the
// entries from the last down to the position up by one, then writes the new value.
// A new command is taken once the result is registered; entries move one per cycle.
// Reset (rst_ni low, asynchronous) empties the list; stored words are not cleared.
`timescale 1ns / 1ps

module positional_insert_delete_array_top #(
  parameter int unsigned DEPTH = pida_pkg::DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pida_in_if.sink     in_i,
  pida_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                        wr_en, rd_en;
  logic [AW-1:0]               wr_addr, rd_addr;
  logic [pida_pkg::DATA_W-1:0] wr_data, rd_data;

  pida_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data)
  );

  pida_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

endmodule

// File: rtl/core/pida_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the insert/delete array
module pida_checker #(
  parameter int unsigned DEPTH = pida_pkg::DEPTH_DEF
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic [pida_pkg::STAT_W-1:0]         status_i,
  input logic signed [pida_pkg::DATA_W-1:0]  data_i,
  input logic [pida_pkg::COUNT_W-1:0]        count_i
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(data_i) && $stable(status_i)
      && $stable(count_i))
    else $error("result changed while stalled");

  // Refused commands return zero data
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != pida_pkg::ST_OK |-> data_i == '0)
    else $error("refused command returned data");

  // Full only reported with a full list
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == pida_pkg::ST_FULL |-> count_i == pida_pkg::COUNT_W'(DEPTH))
    else $error("full status with list not full");

  // One command at a time: busy right after a transfer in
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second command taken while busy");

endmodule

bind positional_insert_delete_array_top pida_checker #(.DEPTH(DEPTH)) u_pida_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .data_i      (out_o.data),
  .count_i     (out_o.count_after)
);

// File: bench/tb_positional_insert_delete_array_top.sv
`timescale 1ns / 1ps

module tb_positional_insert_delete_array_top;

  localparam int unsigned DEPTH     = pida_pkg::DEPTH_DEF;
  localparam int unsigned N_RANDOM  = 1800;
  localparam int unsigned IDLE_PCT  = 27;
  // longest insert walks the whole list; leave margin on top
  localparam int unsigned TAIL_CYC  = 2 * DEPTH + 8;

  typedef struct packed {
    logic [pida_pkg::STAT_W-1:0]         status;
    logic signed [pida_pkg::DATA_W-1:0]  data;
    logic [pida_pkg::COUNT_W-1:0]        count_after;
  } array_result_t;

  // Shadow copy of the list plus the queue of results still owed by the block
  class list_scoreboard;
    logic signed [pida_pkg::DATA_W-1:0] words[DEPTH];
    int unsigned              fill;
    array_result_t            owed[$];
    int unsigned              errors;
    int unsigned              n_ins, n_del, n_rd, n_nop, n_full, n_range, n_checked;
    int unsigned              peak_fill;

    function void note_command(pida_pkg::cmd_e cmd, logic [pida_pkg::POS_W-1:0] pos,
                               logic signed [pida_pkg::DATA_W-1:0] val);
      array_result_t r;
      int unsigned   p;
      p = 32'(pos);
      r.status = pida_pkg::ST_OK;
      r.data   = '0;
      case (cmd)
        pida_pkg::CMD_INSERT: begin
          n_ins++;
          if (p > fill) begin
            r.status = pida_pkg::ST_RANGE;
          end else if (fill >= DEPTH) begin
            r.status = pida_pkg::ST_FULL;
          end else begin
            for (int unsigned k = fill; k > p; k--) words[k] = words[k-1];
            words[p] = val;
            fill++;
          end
        end
        pida_pkg::CMD_DELETE: begin
          n_del++;
          if (p >= fill) begin
            r.status = pida_pkg::ST_RANGE;
          end else begin
            r.data = words[p];
            for (int unsigned k = p; k + 1 < fill; k++) words[k] = words[k+1];
            fill--;
          end
        end
        pida_pkg::CMD_READ: begin
          n_rd++;
          if (p >= fill) r.status = pida_pkg::ST_RANGE;
          else r.data = words[p];
        end
        default: n_nop++;
      endcase
      if (r.status == pida_pkg::ST_FULL) n_full++;
      if (r.status == pida_pkg::ST_RANGE) n_range++;
      if (fill > peak_fill) peak_fill = fill;
      r.count_after = fill[pida_pkg::COUNT_W-1:0];
      owed.push_back(r);
    endfunction

    function void check_result(logic [pida_pkg::STAT_W-1:0] st,
                               logic signed [pida_pkg::DATA_W-1:0] d,
                               logic [pida_pkg::COUNT_W-1:0] cnt);
      array_result_t e;
      if (owed.size() == 0) begin
        $error("result with nothing expected: status=%0d data=%0d count_after=%0d",
               st, d, cnt);
        errors++;
        return;
      end
      e = owed.pop_front();
      n_checked++;
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (d !== e.data) begin
        $error("data: expected %0d, got %0d", e.data, d);
        errors++;
      end
      if (cnt !== e.count_after) begin
        $error("count_after: expected %0d, got %0d", e.count_after, cnt);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   calm;  // suppresses idling on both sides

  pida_in_if  in_if ();
  pida_out_if out_if ();

  list_scoreboard sb;

  positional_insert_delete_array_top #(
    .DEPTH (DEPTH)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Result side: random back-pressure, applied at the falling edge
  always @(negedge clk_i) begin
    out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Result side: check every transfer at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(out_if.status, out_if.data, out_if.count_after);
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // One command transfer, with optional idle cycles ahead of it
  task automatic send_command(input pida_pkg::cmd_e cmd,
                              input logic [pida_pkg::POS_W-1:0] pos,
                              input logic [pida_pkg::DATA_W-1:0] val);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.command  <= cmd;
    in_if.position <= pos;
    in_if.value    <= val;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_command(cmd, pos, val);
    @(negedge clk_i);
  endtask

  // Mostly well-formed commands against the current fill, some noise
  task automatic send_random(input bit grow);
    int unsigned                 roll;
    int unsigned                 n;
    pida_pkg::cmd_e              cmd;
    logic [pida_pkg::POS_W-1:0]  pos;
    logic [pida_pkg::DATA_W-1:0] val;
    n    = sb.fill;
    roll = $urandom_range(99);
    if (roll < 4)                        cmd = pida_pkg::CMD_NOP;
    else if (roll < (grow ? 64 : 30))    cmd = pida_pkg::CMD_INSERT;
    else if (roll < (grow ? 82 : 78))    cmd = pida_pkg::CMD_DELETE;
    else                                 cmd = pida_pkg::CMD_READ;
    if ($urandom_range(99) < 12)
      pos = pida_pkg::POS_W'($urandom_range((1 << pida_pkg::POS_W) - 1));
    else if (cmd == pida_pkg::CMD_INSERT)
      pos = pida_pkg::POS_W'($urandom_range(n));
    else
      pos = (n > 0) ? pida_pkg::POS_W'($urandom_range(n - 1)) : '0;
    case ($urandom_range(19))
      0:       val = 32'h8000_0000;
      1:       val = 32'h7FFF_FFFF;
      2:       val = 32'hFFFF_FFFF;
      3:       val = 32'h0;
      default: val = $urandom;
    endcase
    send_command(cmd, pos, val);
  endtask

  initial begin
    int unsigned guard;
    bit          grow;
    sb = new();
    calm           = 1'b0;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.command  = pida_pkg::CMD_NOP;
    in_if.position = '0;
    in_if.value    = '0;
    out_if.ready   = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty list, edges of the fields, a full list
    send_command(pida_pkg::CMD_READ,   5'd0,  32'd1);
    send_command(pida_pkg::CMD_DELETE, 5'd0,  32'd1);
    send_command(pida_pkg::CMD_INSERT, 5'd1,  32'd9);
    send_command(pida_pkg::CMD_INSERT, 5'd0,  32'h8000_0000);
    send_command(pida_pkg::CMD_INSERT, 5'd1,  32'h7FFF_FFFF);
    send_command(pida_pkg::CMD_INSERT, 5'd0,  32'h0);
    send_command(pida_pkg::CMD_INSERT, 5'd1,  32'hFFFF_FFFF);
    send_command(pida_pkg::CMD_READ,   5'd0,  32'h0);
    send_command(pida_pkg::CMD_READ,   5'd3,  32'hFFFF_FFFF);
    send_command(pida_pkg::CMD_NOP,    5'd31, 32'hFFFF_FFFF);
    send_command(pida_pkg::CMD_DELETE, 5'd1,  32'h0);
    send_command(pida_pkg::CMD_INSERT, 5'd31, 32'h1234_5678);
    while (sb.fill < DEPTH)
      send_command(pida_pkg::CMD_INSERT, pida_pkg::POS_W'($urandom_range(sb.fill)), $urandom);
    send_command(pida_pkg::CMD_INSERT, 5'd5,  32'hA5A5_A5A5);
    send_command(pida_pkg::CMD_INSERT, 5'd17, 32'h5A5A_5A5A);
    send_command(pida_pkg::CMD_DELETE, 5'd16, 32'h0);
    send_command(pida_pkg::CMD_READ,   5'd15, 32'h0);
    send_command(pida_pkg::CMD_DELETE, 5'd15, 32'h0);

    // Random: alternate filling and draining so both ends are reached
    grow = 1'b0;
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if (i % 120 == 0) grow = !grow;
      calm = (i >= 700 && i < 950);
      send_random(grow);
    end
    calm        = 1'b0;
    in_if.valid <= 1'b0;

    // Drain, then let any stray result show up
    guard = 0;
    while (sb.owed.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TAIL_CYC) @(posedge clk_i);
    while (sb.owed.size() != 0) begin
      void'(sb.owed.pop_front());
      $error("expected result never arrived");
      sb.errors++;
    end

    $display("covered %0d inserts, %0d deletes, %0d reads, %0d no-ops; %0d results checked",
             sb.n_ins, sb.n_del, sb.n_rd, sb.n_nop, sb.n_checked);
    $display("refusals: %0d full, %0d out of range; peak fill %0d of %0d",
             sb.n_full, sb.n_range, sb.peak_fill, DEPTH);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
